// ----- design/icymd_pkg.sv -----
// Shared types and constants of the ICY metadata deframer.
package icymd_pkg;

  localparam int unsigned INTERVAL_W  = 20;
  localparam int unsigned META_IDX_W  = 12;
  localparam int unsigned LEN_W       = 8;
  localparam int unsigned UNIT_SHIFT  = 4;
  localparam int unsigned STORE_DEPTH = 4096;
  localparam int unsigned STORE_AW    = $clog2(STORE_DEPTH);

  typedef enum logic [1:0] {
    KIND_AUDIO   = 2'd0,
    KIND_LEN     = 2'd1,
    KIND_CONTENT = 2'd2
  } kind_e;

  typedef struct packed {
    logic [7:0]          data;
    kind_e               kind;
    logic                last;
    logic                in_prev;
    logic                in_store;
    logic                len_diff;
    logic [STORE_AW-1:0] addr;
  } item_t;

  typedef struct packed {
    logic [7:0] data;
    kind_e      kind;
    logic       last;
    logic       changed;
  } result_t;

endpackage

// ----- design/icymd_cmp.sv -----
// Compare stage: metadata store, read-compare-write and change tracking.
module icymd_cmp (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             load_i,
  input  icymd_pkg::item_t item_i,
  input  logic             adv_i,
  output logic             busy_o,
  output icymd_pkg::result_t res_o
);
  import icymd_pkg::*;

  logic [7:0] mem_q [STORE_DEPTH];
  logic [7:0] rdata_q;
  item_t      item_q;
  logic       valid_q, valid_d;
  logic       acc_q, acc_d;
  logic       rd_en;
  logic       wr_en;
  logic       hit;
  logic       merged;
  logic       is_content;

  assign rd_en      = load_i && (item_i.kind == KIND_CONTENT) && item_i.in_store;
  assign is_content = item_q.kind == KIND_CONTENT;
  assign wr_en      = valid_q && adv_i && is_content && item_q.in_store;
  assign hit        = item_q.in_store && (!item_q.in_prev || (rdata_q != item_q.data));
  assign merged     = acc_q || hit;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[item_q.addr] <= item_q.data;
    end
    if (rd_en) begin
      rdata_q <= mem_q[item_i.addr];
    end
    if (load_i) begin
      item_q <= item_i;
    end
  end

  always_comb begin
    valid_d = valid_q;
    acc_d   = acc_q;
    if (valid_q && adv_i) begin
      valid_d = 1'b0;
      if (item_q.kind == KIND_LEN && !item_q.last) begin
        acc_d = item_q.len_diff;
      end else if (is_content) begin
        acc_d = item_q.last ? 1'b0 : merged;
      end
    end
    if (load_i) begin
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      acc_q   <= 1'b0;
    end else begin
      valid_q <= valid_d;
      acc_q   <= acc_d;
    end
  end

  assign busy_o       = valid_q;
  assign res_o.data    = item_q.data;
  assign res_o.kind    = item_q.kind;
  assign res_o.last    = item_q.last;
  assign res_o.changed = is_content && item_q.last && merged;

endmodule

// ----- design/icy_metadata_deframer.sv -----
// Top level of the ICY metadata deframer: framing control, compare stage and output register.
// The deframer takes one stream byte per cycle while not stalled and hands each byte through the
// compare stage and output register once it is accepted, tagged as audio, length or metadata
// content. Framing counters advance when a byte is accepted; the previous metadata block lives
// in a 4096-entry memory with one read and one write port. An entry is read as a content byte
// enters and written back when that byte moves on to the output register, after the comparison.
// Two bytes that touch the same store entry are always at least a length byte apart, so the
// write always lands before the next read of that entry. The input stalls only while the
// compare stage holds a byte and the output register is full and stalled. The interval register
// may be written at any idle time and reloads the audio countdown when its value changes.
module icy_metadata_deframer (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [icymd_pkg::INTERVAL_W-1:0]  meta_interval_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [7:0]                        data_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [7:0]                        out_byte_o,
  output logic [1:0]                        byte_kind_o,
  output logic                              meta_last_o,
  output logic                              title_changed_o
);
  import icymd_pkg::*;

  localparam logic PH_AUDIO = 1'b0;
  localparam logic PH_META  = 1'b1;

  logic [INTERVAL_W-1:0] interval_q, interval_d;
  logic [INTERVAL_W-1:0] countdown_q, countdown_d;
  logic                  phase_q, phase_d;
  logic [META_IDX_W-1:0] remaining_q, remaining_d;
  logic [META_IDX_W-1:0] index_q, index_d;
  logic [LEN_W-1:0]      cur_len_q, cur_len_d;
  logic [LEN_W-1:0]      prev_len_q, prev_len_d;
  logic                  out_valid_q, out_valid_d;
  result_t               out_q;
  logic                  accept;
  logic                  s1_busy;
  logic                  s2_free;
  logic                  adv;
  logic [META_IDX_W-1:0] rem_dec;
  logic [META_IDX_W-1:0] prev_bytes;
  item_t                 item;
  result_t               res;

  assign cfg_ready_o = 1'b1;
  assign s2_free     = !out_valid_q || !out_stall_i;
  assign adv         = s1_busy && s2_free;
  assign in_stall_o  = s1_busy && !s2_free;
  assign accept      = in_valid_i && !in_stall_o;
  assign rem_dec     = remaining_q - META_IDX_W'(1);
  assign prev_bytes  = META_IDX_W'({prev_len_q, UNIT_SHIFT'(0)});

  always_comb begin
    interval_d  = interval_q;
    countdown_d = countdown_q;
    phase_d     = phase_q;
    remaining_d = remaining_q;
    index_d     = index_q;
    cur_len_d   = cur_len_q;
    prev_len_d  = prev_len_q;

    item.data     = data_byte_i;
    item.kind     = KIND_AUDIO;
    item.last     = 1'b0;
    item.in_prev  = index_q < prev_bytes;
    item.in_store = {1'b0, index_q} < (META_IDX_W + 1)'(STORE_DEPTH);
    item.len_diff = data_byte_i != prev_len_q;
    item.addr     = STORE_AW'(index_q);

    if (accept) begin
      if (phase_q == PH_META) begin
        item.kind   = KIND_CONTENT;
        index_d     = index_q + META_IDX_W'(1);
        remaining_d = rem_dec;
        if (rem_dec == '0) begin
          item.last   = 1'b1;
          prev_len_d  = cur_len_q;
          countdown_d = interval_q;
          phase_d     = PH_AUDIO;
        end
      end else if (interval_q == '0 || countdown_q != '0) begin
        if (interval_q != '0) begin
          countdown_d = countdown_q - INTERVAL_W'(1);
        end
      end else begin
        item.kind = KIND_LEN;
        if (data_byte_i == '0) begin
          item.last   = 1'b1;
          countdown_d = interval_q;
        end else begin
          cur_len_d   = data_byte_i;
          remaining_d = META_IDX_W'({data_byte_i, UNIT_SHIFT'(0)});
          index_d     = '0;
          phase_d     = PH_META;
        end
      end
    end

    if (cfg_valid_i && meta_interval_i != interval_q) begin
      interval_d  = meta_interval_i;
      countdown_d = meta_interval_i;
    end
  end

  icymd_cmp u_cmp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .load_i (accept),
    .item_i (item),
    .adv_i  (adv),
    .busy_o (s1_busy),
    .res_o  (res)
  );

  assign out_valid_d = adv || (out_valid_q && out_stall_i);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q  <= '0;
      countdown_q <= '0;
      phase_q     <= PH_AUDIO;
      remaining_q <= '0;
      index_q     <= '0;
      cur_len_q   <= '0;
      prev_len_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      interval_q  <= interval_d;
      countdown_q <= countdown_d;
      phase_q     <= phase_d;
      remaining_q <= remaining_d;
      index_q     <= index_d;
      cur_len_q   <= cur_len_d;
      prev_len_q  <= prev_len_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign out_byte_o      = out_q.data;
  assign byte_kind_o     = out_q.kind;
  assign meta_last_o     = out_q.last;
  assign title_changed_o = out_q.changed;

  a_stall_needs_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_busy |-> !in_stall_o)
    else $error("input stalled with an empty compare stage");

  a_meta_has_bytes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    phase_q == PH_META |-> remaining_q != '0)
    else $error("metadata phase with no bytes left");

  a_changed_only_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && title_changed_o |-> meta_last_o && byte_kind_o == KIND_CONTENT)
    else $error("change flag outside the final content byte");

  a_audio_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && byte_kind_o == KIND_AUDIO |-> !meta_last_o)
    else $error("audio byte marked as block end");

endmodule

// ----- tb/tb_icy_metadata_deframer.sv -----
// Self-checking testbench of the ICY metadata deframer: framed random streams against a predictor.
module tb_icy_metadata_deframer;
  timeunit 1ns;
  timeprecision 1ps;

  import icymd_pkg::*;

  class frame_tracker;
    logic [INTERVAL_W-1:0] interval;
    logic [INTERVAL_W-1:0] countdown;
    bit                    in_block;
    int                    bytes_left;
    logic [STORE_AW-1:0]   pos;
    logic [7:0]            cur_units;
    logic [7:0]            prev_units;
    bit                    differs;
    logic [7:0]            store [STORE_DEPTH];
    result_t               pending_bytes [$];
    int                    errors;

    function new();
      interval = '0;
      countdown = '0;
      in_block = 1'b0;
      bytes_left = 0;
      pos = '0;
      cur_units = '0;
      prev_units = '0;
      differs = 1'b0;
      errors = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function void write_interval(logic [INTERVAL_W-1:0] value);
      if (value != interval) begin
        interval = value;
        countdown = value;
      end
    endfunction

    function void take_byte(logic [7:0] b);
      result_t r;
      r.data = b;
      r.kind = KIND_AUDIO;
      r.last = 1'b0;
      r.changed = 1'b0;
      if (in_block) begin
        r.kind = KIND_CONTENT;
        if (pos < prev_units * 16) begin
          if (store[pos] != b) differs = 1'b1;
        end else begin
          differs = 1'b1;
        end
        store[pos] = b;
        pos++;
        bytes_left--;
        if (bytes_left == 0) begin
          r.last = 1'b1;
          r.changed = differs;
          prev_units = cur_units;
          countdown = interval;
          in_block = 1'b0;
          differs = 1'b0;
        end
      end else if (interval == 0 || countdown != 0) begin
        if (interval != 0) countdown--;
      end else begin
        r.kind = KIND_LEN;
        if (b == 8'd0) begin
          countdown = interval;
          r.last = 1'b1;
        end else begin
          cur_units = b;
          bytes_left = b * 16;
          pos = '0;
          differs = (b != prev_units);
          in_block = 1'b1;
        end
      end
      pending_bytes.push_back(r);
    endfunction

    function void check_byte(result_t got);
      result_t want;
      if (pending_bytes.size() == 0) begin
        $display("%0t: unexpected transfer: byte %h kind %0d last %b changed %b",
                 $time, got.data, got.kind, got.last, got.changed);
        errors++;
        return;
      end
      want = pending_bytes.pop_front();
      if (got.data !== want.data) begin
        $display("%0t: out_byte expected %h actual %h", $time, want.data, got.data);
        errors++;
      end
      if (got.kind !== want.kind) begin
        $display("%0t: byte_kind expected %0d actual %0d", $time, want.kind, got.kind);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: meta_last expected %b actual %b", $time, want.last, got.last);
        errors++;
      end
      if (got.changed !== want.changed) begin
        $display("%0t: title_changed expected %b actual %b", $time, want.changed, got.changed);
        errors++;
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [INTERVAL_W-1:0] meta_interval_i = '0;
  logic                  in_valid_i = 1'b0;
  logic                  in_stall_o;
  logic [7:0]            data_byte_i = '0;
  logic                  out_valid_o;
  logic                  out_stall_i = 1'b0;
  logic [7:0]            out_byte_o;
  logic [1:0]            byte_kind_o;
  logic                  meta_last_o;
  logic                  title_changed_o;

  frame_tracker tracker = new();
  bit           calm = 1'b1;
  bit           mirror = 1'b0;

  icy_metadata_deframer dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .meta_interval_i (meta_interval_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_byte_o      (out_byte_o),
    .byte_kind_o     (byte_kind_o),
    .meta_last_o     (meta_last_o),
    .title_changed_o (title_changed_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 6);
  end

  always @(posedge clk_i) begin
    result_t got;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got.data = out_byte_o;
      got.kind = kind_e'(byte_kind_o);
      got.last = meta_last_o;
      got.changed = title_changed_o;
      tracker.check_byte(got);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    while (!calm && $urandom_range(0, 99) < 6) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    data_byte_i <= b;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    tracker.take_byte(b);
  endtask

  task automatic set_interval(input logic [INTERVAL_W-1:0] value);
    in_valid_i <= 1'b0;
    while (tracker.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid_i <= 1'b1;
    meta_interval_i <= value;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    tracker.write_interval(value);
  endtask

  // Picks the next stream byte so that length bytes land where the framing expects them.
  task automatic feed_stream(input int unsigned force_units, output bit was_len);
    logic [7:0]  b;
    int unsigned roll;
    was_len = 1'b0;
    b = 8'($urandom_range(0, 255));
    if (tracker.in_block) begin
      if (mirror && tracker.pos < tracker.prev_units * 16) begin
        b = tracker.store[tracker.pos];
        if (force_units == 0 && $urandom_range(0, 63) == 0) b = b ^ (8'd1 << $urandom_range(0, 7));
      end
    end else if (tracker.interval != 0 && tracker.countdown == 0) begin
      was_len = 1'b1;
      roll = $urandom_range(0, 99);
      mirror = ($urandom_range(0, 4) != 0);
      if (force_units != 0) begin
        b = 8'(force_units);
        mirror = 1'b1;
      end else if (roll < 15) begin
        b = 8'd0;
      end else if (roll < 60 && tracker.prev_units != 0) begin
        b = tracker.prev_units;
      end else if (roll < 95) begin
        b = 8'($urandom_range(1, 3));
      end else begin
        b = 8'($urandom_range(4, 12));
      end
    end
    send_byte(b);
  endtask

  task automatic run_phase(input logic [INTERVAL_W-1:0] value, input int count, input bit quiet);
    bit was_len;
    set_interval(value);
    calm = quiet || ($urandom_range(0, 3) == 0);
    repeat (count) feed_stream(0, was_len);
  endtask

  initial begin
    int big;
    bit was_len;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_byte(8'h00);
    send_byte(8'hFF);
    set_interval(0);
    send_byte(8'hA5);
    set_interval(1);
    send_byte(8'h3C);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(8'h01);
    for (int i = 0; i < 16; i++) send_byte(8'(i * 17));

    run_phase(2, 200, 1'b0);
    run_phase(20'hFFFFF, 40, 1'b0);
    run_phase(5, 200, 1'b1);
    run_phase(0, 60, 1'b0);
    run_phase(1, 150, 1'b0);
    run_phase(1, 100, 1'b0);
    run_phase(INTERVAL_W'($urandom_range(6, 40)), 150, 1'b0);
    run_phase(INTERVAL_W'($urandom_range(0, 20'hFFFFF)), 40, 1'b0);
    run_phase(3, 120, 1'b1);

    set_interval(1);
    calm = 1'b0;
    big = 0;
    while (big < 2 || tracker.in_block) begin
      feed_stream(20, was_len);
      if (was_len) big++;
    end

    in_valid_i <= 1'b0;
    while (tracker.pending_bytes.size() != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (tracker.errors == 0) begin
      $display("tb_icy_metadata_deframer: done, clean");
    end else begin
      $display("tb_icy_metadata_deframer: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("tb_icy_metadata_deframer: done, errors");
    $finish;
  end

endmodule
